>>> sv/htpb_pkg.sv
`default_nettype none

package htpb_pkg;

   // Field and register widths.
   localparam int unsigned COLOR_W    = 16;
   localparam int unsigned INDEX_W    = 16;
   localparam int unsigned HOUR_W     = 5;
   localparam int unsigned MIN_W      = 6;
   localparam int unsigned STR_W      = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   // Datapath widths.
   localparam int unsigned HOURS    = 24;
   localparam int unsigned NUM_CH   = 3;
   localparam int unsigned CH_W     = 5;
   localparam int unsigned GAIN_W   = 9;
   localparam int unsigned WEIGHT_W = 9;
   localparam int unsigned PCT_W    = 7;
   localparam int unsigned TINT_W   = 8;
   localparam int unsigned PROD_W   = 15;
   localparam int unsigned MIX_W    = 15;
   localparam int unsigned NUMER_W  = 23;
   localparam int unsigned DEN_W    = 15;
   localparam int unsigned RECIP_W  = 11;

   // Number of register stages inside the gain unit.
   localparam int unsigned GAIN_LAT = 5;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOUR     = 2'd0,
      CSR_MINUTE   = 2'd1,
      CSR_STRENGTH = 2'd2
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [HOUR_W-1:0] HOUR_RESET     = 5'd0;
   localparam logic [MIN_W-1:0]  MINUTE_RESET   = 6'd0;
   localparam logic [STR_W-1:0]  STRENGTH_RESET = 8'd20;

   // Time constants.
   localparam logic [HOUR_W-1:0] LAST_HOUR    = 5'd23;
   localparam logic [HOUR_W-1:0] HOURS_CONST  = 5'd24;
   localparam logic [MIN_W-1:0]  MIN_PER_HOUR = 6'd60;
   localparam logic [MIN_W-1:0]  LAST_MINUTE  = 6'd59;

   // Fixed-point constants.
   localparam logic [GAIN_W-1:0]   GAIN_ONE = 9'd256;
   localparam logic [PCT_W-1:0]    PCT_FULL = 7'd100;
   localparam logic [CH_W-1:0]     CH_MAX   = 5'd31;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

   // Rounding term of the gain quotient is half the denominator, 50 * max.
   localparam logic [NUMER_W-1:0] HALF_DEN_MUL = 23'd50;

   // x / 10 for x below 2^15: (x * 52429) >> 19 is exact.
   localparam int unsigned        DIV10_MUL_W = 16;
   localparam logic [15:0]        DIV10_MUL   = 16'd52429;
   localparam int unsigned        DIV10_SHIFT = 19;

   // 256 * m / 60 for m below 60: (m * 279680) >> 16 is exact.
   localparam int unsigned        MINW_PROD_W = 25;
   localparam logic [18:0]        MINW_MUL    = 19'd279680;
   localparam int unsigned        MINW_SHIFT  = 16;

   // Gain quotient via reciprocal: floor(2^23 / den), one correction step.
   localparam int unsigned        RECIP_SHIFT = 23;

   typedef logic [GAIN_W-1:0] gain_type;
   typedef gain_type [NUM_CH-1:0] gain_vec_type;

   // Hour tint table, channels in red, green, blue order.
   localparam logic [TINT_W-1:0] TINT_CH [HOURS][NUM_CH] = '{
      '{8'd20,  8'd30,  8'd70},  '{8'd15,  8'd25,  8'd65},  '{8'd12,  8'd22,  8'd60},
      '{8'd18,  8'd28,  8'd62},  '{8'd40,  8'd40,  8'd90},  '{8'd80,  8'd60,  8'd120},
      '{8'd160, 8'd80,  8'd140}, '{8'd255, 8'd140, 8'd80},  '{8'd255, 8'd180, 8'd120},
      '{8'd255, 8'd200, 8'd150}, '{8'd255, 8'd215, 8'd180}, '{8'd255, 8'd235, 8'd210},
      '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd240},
      '{8'd255, 8'd250, 8'd220}, '{8'd255, 8'd220, 8'd160}, '{8'd255, 8'd180, 8'd100},
      '{8'd255, 8'd120, 8'd80},  '{8'd200, 8'd80,  8'd160}, '{8'd140, 8'd60,  8'd140},
      '{8'd90,  8'd50,  8'd120}, '{8'd50,  8'd40,  8'd100}, '{8'd25,  8'd35,  8'd85}
   };

   // Blend percent per hour.
   localparam logic [PCT_W-1:0] TINT_PCT [HOURS] = '{
      7'd55, 7'd60, 7'd65, 7'd62, 7'd55, 7'd45, 7'd35, 7'd25, 7'd20, 7'd15, 7'd10, 7'd5,
      7'd0,  7'd0,  7'd3,  7'd5,  7'd10, 7'd20, 7'd30, 7'd40, 7'd45, 7'd50, 7'd52, 7'd54
   };

   // Dominant channel per hour.
   localparam logic [TINT_W-1:0] TINT_MAX [HOURS] = '{
      8'd70,  8'd65,  8'd60,  8'd62,  8'd90,  8'd120, 8'd160, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd200, 8'd140, 8'd120, 8'd100, 8'd85
   };

   // Gain denominator, 100 times the dominant channel.
   localparam logic [DEN_W-1:0] TINT_DEN [HOURS] = '{
      DEN_W'(100*70),  DEN_W'(100*65),  DEN_W'(100*60),  DEN_W'(100*62),
      DEN_W'(100*90),  DEN_W'(100*120), DEN_W'(100*160), DEN_W'(100*255),
      DEN_W'(100*255), DEN_W'(100*255), DEN_W'(100*255), DEN_W'(100*255),
      DEN_W'(100*255), DEN_W'(100*255), DEN_W'(100*255), DEN_W'(100*255),
      DEN_W'(100*255), DEN_W'(100*255), DEN_W'(100*255), DEN_W'(100*200),
      DEN_W'(100*140), DEN_W'(100*120), DEN_W'(100*100), DEN_W'(100*85)
   };

   // Reciprocal of the denominator, scaled by 2^23 and rounded down.
   localparam logic [RECIP_W-1:0] TINT_RECIP [HOURS] = '{
      RECIP_W'(8388608/(100*70)),  RECIP_W'(8388608/(100*65)),
      RECIP_W'(8388608/(100*60)),  RECIP_W'(8388608/(100*62)),
      RECIP_W'(8388608/(100*90)),  RECIP_W'(8388608/(100*120)),
      RECIP_W'(8388608/(100*160)), RECIP_W'(8388608/(100*255)),
      RECIP_W'(8388608/(100*255)), RECIP_W'(8388608/(100*255)),
      RECIP_W'(8388608/(100*255)), RECIP_W'(8388608/(100*255)),
      RECIP_W'(8388608/(100*255)), RECIP_W'(8388608/(100*255)),
      RECIP_W'(8388608/(100*255)), RECIP_W'(8388608/(100*255)),
      RECIP_W'(8388608/(100*255)), RECIP_W'(8388608/(100*255)),
      RECIP_W'(8388608/(100*255)), RECIP_W'(8388608/(100*200)),
      RECIP_W'(8388608/(100*140)), RECIP_W'(8388608/(100*120)),
      RECIP_W'(8388608/(100*100)), RECIP_W'(8388608/(100*85))
   };

endpackage

`default_nettype wire

>>> sv/htpb_gain.sv
`default_nettype none

// Five-stage pipeline that turns an hour and a strength into three channel gains.
module htpb_gain (
   input  logic                          clock,
   input  logic [htpb_pkg::HOUR_W-1:0]   hour,
   input  logic [htpb_pkg::STR_W-1:0]    strength,
   output htpb_pkg::gain_vec_type        gain
);

   localparam int unsigned EFF_PROD_W = htpb_pkg::PROD_W + htpb_pkg::DIV10_MUL_W;
   localparam int unsigned TENTH_W    = EFF_PROD_W - htpb_pkg::DIV10_SHIFT;
   localparam int unsigned QPROD_W    = htpb_pkg::NUMER_W + htpb_pkg::RECIP_W;
   localparam int unsigned REM_W      = htpb_pkg::NUMER_W + 1;

   logic [htpb_pkg::HOUR_W-1:0]  hour1_ff, hour2_ff, hour3_ff, hour4_ff;
   logic [htpb_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [htpb_pkg::PCT_W-1:0]   eff_ff, eff_in;
   logic [htpb_pkg::NUMER_W-1:0] numer_ff [htpb_pkg::NUM_CH];
   logic [htpb_pkg::NUMER_W-1:0] numer_in [htpb_pkg::NUM_CH];
   logic [htpb_pkg::NUMER_W-1:0] numer4_ff [htpb_pkg::NUM_CH];
   logic [htpb_pkg::GAIN_W-1:0]  quot_ff [htpb_pkg::NUM_CH];
   logic [htpb_pkg::GAIN_W-1:0]  quot_in [htpb_pkg::NUM_CH];
   htpb_pkg::gain_vec_type       gain_ff, gain_in;

   logic [EFF_PROD_W-1:0] eff_prod;
   logic [TENTH_W-1:0]    tenth;

   // Stage one: blend percent times strength.
   assign prod_in = htpb_pkg::PROD_W'(htpb_pkg::TINT_PCT[hour])
                  * htpb_pkg::PROD_W'(strength);

   // Stage two: divide by ten and cap at full blend.
   always_comb begin
      eff_prod = EFF_PROD_W'(prod_ff) * EFF_PROD_W'(htpb_pkg::DIV10_MUL);
      tenth    = eff_prod[EFF_PROD_W-1:htpb_pkg::DIV10_SHIFT];
      if (tenth > TENTH_W'(htpb_pkg::PCT_FULL)) begin
         eff_in = htpb_pkg::PCT_FULL;
      end else begin
         eff_in = tenth[htpb_pkg::PCT_W-1:0];
      end
   end

   // Stage three: numerator 256 * mix plus half the denominator, per channel.
   always_comb begin
      logic [htpb_pkg::MIX_W-1:0] mix;
      logic [htpb_pkg::TINT_W-1:0] mx;
      mx = htpb_pkg::TINT_MAX[hour2_ff];
      for (int k = 0; k < htpb_pkg::NUM_CH; k++) begin
         mix = htpb_pkg::MIX_W'(htpb_pkg::PCT_FULL - eff_ff) * htpb_pkg::MIX_W'(mx)
             + htpb_pkg::MIX_W'(eff_ff) * htpb_pkg::MIX_W'(htpb_pkg::TINT_CH[hour2_ff][k]);
         numer_in[k] = {mix, 8'h00}
                     + htpb_pkg::NUMER_W'(mx) * htpb_pkg::HALF_DEN_MUL;
      end
   end

   // Stage four: quotient estimate from the reciprocal, low by at most one.
   always_comb begin
      logic [QPROD_W-1:0] qprod;
      for (int k = 0; k < htpb_pkg::NUM_CH; k++) begin
         qprod = QPROD_W'(numer_ff[k]) * QPROD_W'(htpb_pkg::TINT_RECIP[hour3_ff]);
         quot_in[k] = qprod[htpb_pkg::RECIP_SHIFT +: htpb_pkg::GAIN_W];
      end
   end

   // Stage five: correct the estimate and cap at unity gain.
   always_comb begin
      logic [REM_W-1:0]            rem;
      logic [htpb_pkg::GAIN_W:0]   q;
      logic [htpb_pkg::DEN_W-1:0]  den;
      den = htpb_pkg::TINT_DEN[hour4_ff];
      for (int k = 0; k < htpb_pkg::NUM_CH; k++) begin
         rem = REM_W'(numer4_ff[k]) - REM_W'(quot_ff[k]) * REM_W'(den);
         if (rem >= REM_W'(den)) begin
            q = {1'b0, quot_ff[k]} + 1'b1;
         end else begin
            q = {1'b0, quot_ff[k]};
         end
         if (q > {1'b0, htpb_pkg::GAIN_ONE}) begin
            gain_in[k] = htpb_pkg::GAIN_ONE;
         end else begin
            gain_in[k] = q[htpb_pkg::GAIN_W-1:0];
         end
      end
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      hour1_ff <= hour;
      prod_ff  <= prod_in;
      hour2_ff <= hour1_ff;
      eff_ff   <= eff_in;
      hour3_ff <= hour2_ff;
      numer_ff <= numer_in;
      hour4_ff <= hour3_ff;
      numer4_ff <= numer_ff;
      quot_ff  <= quot_in;
      gain_ff  <= gain_in;
   end

   assign gain = gain_ff;

endmodule

`default_nettype wire

>>> sv/hour_tint_palette_blend.sv
// Time-of-day tint for a stream of BGR555 palette colors.
//
// Input beats: drive req_color_in and req_entry_index with start high; the beat
// is taken at any rising edge where start is high and busy is low. busy is high
// only while reset is asserted, so a new beat can be taken in every cycle.
// Result beats: rsp_valid is high for one cycle with rsp_color_out and
// rsp_passed_through. A result passes the input, delay-line, scale and blend
// registers in turn; results leave in input order at one per cycle.
// The receiver cannot stall, so the pipeline never holds.
// Latency is set by the gain unit (five stages: percent product, divide by ten,
// numerator, reciprocal multiply, correction) plus input, scale and blend stages.
// Configuration: csr_we with csr_index and csr_wdata writes hour, minute or
// strength; write only while no beats are in flight.
// Reset (synchronous, active high) clears all valid bits and sets hour 0,
// minute 0 and strength 20.
`default_nettype none

module hour_tint_palette_blend (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [htpb_pkg::COLOR_W-1:0]       req_color_in,
   input  logic [htpb_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic                               csr_we,
   input  logic [htpb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [htpb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                               rsp_valid,
   output logic [htpb_pkg::COLOR_W-1:0]       rsp_color_out,
   output logic                               rsp_passed_through
);

   localparam int unsigned CW = htpb_pkg::CH_W;
   localparam int unsigned NC = htpb_pkg::NUM_CH;

   typedef struct packed {
      logic [htpb_pkg::COLOR_W-1:0]  color;
      logic                          trans;
      logic [htpb_pkg::WEIGHT_W-1:0] weight;
   } item_type;

   // Configuration registers.
   logic [htpb_pkg::HOUR_W-1:0] hour_ff;
   logic [htpb_pkg::MIN_W-1:0]  minute_ff;
   logic [htpb_pkg::STR_W-1:0]  strength_ff;

   // Input stage.
   logic                          accept;
   logic                          s1_valid_ff;
   item_type                      s1_item_ff, s1_item_in;
   logic [htpb_pkg::HOUR_W-1:0]   h0_ff, h0_in, h1_ff, h1_in;
   logic [htpb_pkg::STR_W-1:0]    s1_str_ff;

   // Alignment with the gain unit.
   logic     dly_valid_ff [htpb_pkg::GAIN_LAT];
   item_type dly_item_ff  [htpb_pkg::GAIN_LAT];
   htpb_pkg::gain_vec_type gain_cur, gain_nxt;

   // Scale and blend stages.
   logic                 s7_valid_ff;
   item_type             s7_item_ff;
   logic [CW-1:0]        cur_ff [NC], cur_in [NC];
   logic [CW-1:0]        nxt_ff [NC], nxt_in [NC];
   logic                 out_valid_ff;
   logic [htpb_pkg::COLOR_W-1:0] out_color_ff, out_color_in;
   logic                 out_trans_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff     <= htpb_pkg::HOUR_RESET;
         minute_ff   <= htpb_pkg::MINUTE_RESET;
         strength_ff <= htpb_pkg::STRENGTH_RESET;
      end else if (csr_we) begin
         unique case (htpb_pkg::csr_index_type'(csr_index))
            htpb_pkg::CSR_HOUR:     hour_ff     <= csr_wdata[htpb_pkg::HOUR_W-1:0];
            htpb_pkg::CSR_MINUTE:   minute_ff   <= csr_wdata[htpb_pkg::MIN_W-1:0];
            htpb_pkg::CSR_STRENGTH: strength_ff <= csr_wdata[htpb_pkg::STR_W-1:0];
            default: ;
         endcase
      end
   end

   // Map hour over 23 to 0, clamp minute, pick the next hour, form minute weight.
   always_comb begin
      logic [htpb_pkg::MIN_W-1:0]       m;
      logic [htpb_pkg::MINW_PROD_W-1:0] mprod;
      if (hour_ff < htpb_pkg::HOURS_CONST) begin
         h0_in = hour_ff;
      end else begin
         h0_in = '0;
      end
      if (h0_in == htpb_pkg::LAST_HOUR) begin
         h1_in = '0;
      end else begin
         h1_in = h0_in + 1'b1;
      end
      if (minute_ff < htpb_pkg::MIN_PER_HOUR) begin
         m = minute_ff;
      end else begin
         m = htpb_pkg::LAST_MINUTE;
      end
      mprod = htpb_pkg::MINW_PROD_W'(m) * htpb_pkg::MINW_PROD_W'(htpb_pkg::MINW_MUL);
      s1_item_in.weight = htpb_pkg::WEIGHT_ONE
                        - htpb_pkg::WEIGHT_W'(mprod[htpb_pkg::MINW_PROD_W-1:htpb_pkg::MINW_SHIFT]);
      s1_item_in.color  = req_color_in;
      s1_item_in.trans  = (req_entry_index[3:0] == 4'd0);
   end

   // Input register stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      h0_ff      <= h0_in;
      h1_ff      <= h1_in;
      s1_str_ff  <= strength_ff;
   end

   // Gains for the current hour and the next hour.
   htpb_gain u_gain_cur (
      .clock    (clock),
      .hour     (h0_ff),
      .strength (s1_str_ff),
      .gain     (gain_cur)
   );

   htpb_gain u_gain_nxt (
      .clock    (clock),
      .hour     (h1_ff),
      .strength (s1_str_ff),
      .gain     (gain_nxt)
   );

   // Delay line that keeps each beat beside its gains.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < htpb_pkg::GAIN_LAT; i++) begin
            dly_valid_ff[i] <= 1'b0;
         end
      end else begin
         dly_valid_ff[0] <= s1_valid_ff;
         for (int i = 1; i < htpb_pkg::GAIN_LAT; i++) begin
            dly_valid_ff[i] <= dly_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dly_item_ff[0] <= s1_item_ff;
      for (int i = 1; i < htpb_pkg::GAIN_LAT; i++) begin
         dly_item_ff[i] <= dly_item_ff[i-1];
      end
   end

   // Scale each channel by both gains and clamp to the channel range.
   always_comb begin
      logic [CW-1:0]                  c;
      logic [htpb_pkg::GAIN_W+CW-1:0] pc, pn;
      for (int k = 0; k < NC; k++) begin
         c  = dly_item_ff[htpb_pkg::GAIN_LAT-1].color[k*CW +: CW];
         pc = (htpb_pkg::GAIN_W+CW)'(gain_cur[k]) * (htpb_pkg::GAIN_W+CW)'(c);
         pn = (htpb_pkg::GAIN_W+CW)'(gain_nxt[k]) * (htpb_pkg::GAIN_W+CW)'(c);
         if (pc[htpb_pkg::GAIN_W+CW-1:8] > (htpb_pkg::GAIN_W+CW-8)'(htpb_pkg::CH_MAX)) begin
            cur_in[k] = htpb_pkg::CH_MAX;
         end else begin
            cur_in[k] = pc[8 +: CW];
         end
         if (pn[htpb_pkg::GAIN_W+CW-1:8] > (htpb_pkg::GAIN_W+CW-8)'(htpb_pkg::CH_MAX)) begin
            nxt_in[k] = htpb_pkg::CH_MAX;
         end else begin
            nxt_in[k] = pn[8 +: CW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= dly_valid_ff[htpb_pkg::GAIN_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      s7_item_ff <= dly_item_ff[htpb_pkg::GAIN_LAT-1];
      cur_ff     <= cur_in;
      nxt_ff     <= nxt_in;
   end

   // Blend toward the next hour with a flooring shift, then assemble the color.
   always_comb begin
      logic signed [CW:0]                   diff;
      logic signed [htpb_pkg::WEIGHT_W:0]   w;
      logic signed [15:0]                   prod;
      logic signed [15:0]                   sum;
      out_color_in = '0;
      w = $signed({1'b0, s7_item_ff.weight});
      for (int k = 0; k < NC; k++) begin
         diff = $signed({1'b0, cur_ff[k]}) - $signed({1'b0, nxt_ff[k]});
         prod = diff * w;
         sum  = $signed(16'(nxt_ff[k])) + (prod >>> 8);
         out_color_in[k*CW +: CW] = sum[CW-1:0];
      end
      if (s7_item_ff.trans) begin
         out_color_in = s7_item_ff.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_color_ff <= out_color_in;
      out_trans_ff <= s7_item_ff.trans;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_color_out      = out_color_ff;
   assign rsp_passed_through = out_trans_ff;

endmodule

`default_nettype wire

>>> sv/htpb_checker.sv
`default_nettype none

// Port-level checks of latency, pass-through and the cleared top bit.
module htpb_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [htpb_pkg::COLOR_W-1:0]    req_color_in,
   input  logic [htpb_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic                            rsp_valid,
   input  logic [htpb_pkg::COLOR_W-1:0]    rsp_color_out,
   input  logic                            rsp_passed_through
);

   logic accept;
   assign accept = start && !busy;

   // Every accepted beat yields a result.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##8 rsp_valid)
      else $error("accepted beat produced no result on time");

   // No result appears without a matching accepted beat.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 8))
      else $error("result without a matching input beat");

   // A transparent entry comes back unchanged and flagged.
   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      (accept && req_entry_index[3:0] == 4'd0) |->
         ##8 (rsp_passed_through && rsp_color_out == $past(req_color_in, 8)))
      else $error("transparent entry was altered");

   // A tinted result is never flagged and has its top bit clear.
   a_tinted: assert property (@(posedge clock) disable iff (reset)
      (accept && req_entry_index[3:0] != 4'd0) |->
         ##8 (!rsp_passed_through && !rsp_color_out[15]))
      else $error("tinted result flagged or top bit set");

endmodule

bind hour_tint_palette_blend htpb_checker u_htpb_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_color_in       (req_color_in),
   .req_entry_index    (req_entry_index),
   .rsp_valid          (rsp_valid),
   .rsp_color_out      (rsp_color_out),
   .rsp_passed_through (rsp_passed_through)
);

`default_nettype wire
